// ----- rtl/core/text_format_sniffer_unit_defines.svh -----
// Assertion helpers for the text format sniffer.
`ifndef TEXT_FORMAT_SNIFFER_UNIT_DEFINES_SVH
`define TEXT_FORMAT_SNIFFER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define TFS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("tfs assertion failed");

`define TFS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("tfs forbidden condition seen");

`else

`define TFS_ASSERT(lbl, clk, rst_n, prop)

`define TFS_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ----- rtl/core/tfs_pkg.sv -----
package tfs_pkg;

	typedef logic [7:0]  byte_val_t;
	typedef logic [1:0]  code_t;
	typedef logic [1:0]  cfg_idx_t;
	typedef logic [11:0] cfg_data_t;
	typedef logic [12:0] pos_t;

	localparam cfg_idx_t REG_ENCODING_WINDOW = 2'd0;
	localparam cfg_idx_t REG_EOL_WINDOW      = 2'd1;

	localparam cfg_data_t ENC_WINDOW_RESET = 12'd1000;
	localparam logic [7:0] EOL_WINDOW_RESET = 8'd50;

	localparam pos_t POS_MAX = 13'd8191;

	localparam code_t ENC_ANSI     = 2'd0;
	localparam code_t ENC_UTF16LE  = 2'd1;
	localparam code_t ENC_UTF16BE  = 2'd2;
	localparam code_t ENC_UTF8     = 2'd3;

	localparam code_t CP_ENGLISH   = 2'd0;
	localparam code_t CP_OEM       = 2'd1;
	localparam code_t CP_UNICODE   = 2'd2;

	localparam code_t EOL_CRLF     = 2'd0;
	localparam code_t EOL_LF       = 2'd1;
	localparam code_t EOL_CR       = 2'd2;

	localparam code_t BOM_NONE     = 2'd0;
	localparam code_t BOM_UTF16    = 2'd2;
	localparam code_t BOM_UTF8     = 2'd3;

	localparam byte_val_t CHAR_LF  = 8'h0A;
	localparam byte_val_t CHAR_CR  = 8'h0D;
	localparam byte_val_t CHAR_NUL = 8'h00;

	// bit 0 CRLF, bit 1 LF, bit 2 CR
	typedef logic [2:0] eol_flags_t;

endpackage

// ----- rtl/core/tfs_intf.sv -----
interface tfs_in_if;
	import tfs_pkg::*;
	logic      valid;
	logic      ready;
	byte_val_t data_byte;
	logic      last_byte;
	modport source (output valid, data_byte, last_byte, input ready);
	modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface tfs_out_if;
	import tfs_pkg::*;
	logic  valid;
	logic  ready;
	code_t text_encoding;
	code_t code_page;
	code_t line_ending;
	code_t bom_length;
	modport source (output valid, text_encoding, code_page, line_ending, bom_length,
		input ready);
	modport sink   (input valid, text_encoding, code_page, line_ending, bom_length,
		output ready);
endinterface

interface tfs_cfg_if;
	import tfs_pkg::*;
	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	cfg_data_t data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/text_format_sniffer_unit.sv -----
// Channel   Role  Transaction
// bytes     sink  one file byte (data_byte, last_byte)
// verdict   src   one result per file, on the last byte
// cfg       sink  register write (index, data), always ready
//
// One byte per cycle while bytes.ready is high; the verdict is registered and appears in the cycle after its last byte.
// Flags and counters update as each byte is taken, the verdict register
// sits after that logic. bytes.ready drops only while a verdict waits
// and verdict.ready is low. Reset clears all file state and loads the
// register defaults (window 1000, eol window 50).
`include "text_format_sniffer_unit_defines.svh"

module text_format_sniffer_unit (
	input  logic          clk,
	input  logic          arst_n,
	tfs_in_if.sink        bytes,
	tfs_out_if.source     verdict,
	tfs_cfg_if.sink       cfg
);
	import tfs_pkg::*;

	function automatic code_t pick_ending(eol_flags_t f);
		code_t r;
		if (f[0])      r = EOL_CRLF;
		else if (f[1]) r = EOL_LF;
		else if (f[2]) r = EOL_CR;
		else           r = EOL_CRLF;
		return r;
	endfunction

	cfg_data_t  enc_window_q;
	logic [7:0] eol_window_q;

	byte_val_t  head_q [3];
	pos_t       pos_q;
	logic       ascii_q;
	logic       invalid_q;
	logic [2:0] cont_q;
	byte_val_t  recent_q [3];
	eol_flags_t flags_byte_q, flags_le_q, flags_be_q;

	logic  out_valid_q;
	code_t enc_q, page_q, eol_q, bom_q;

	logic       accept;
	byte_val_t  b;
	byte_val_t  head_n [3];
	logic       ascii_n, invalid_n;
	logic [2:0] cont_n;
	eol_flags_t flags_byte_n, flags_le_n, flags_be_n;
	logic       mark_utf8;
	logic [8:0] byte_limit, wide_limit;
	logic       p_ge1, p_ge3;
	code_t      enc_n, page_n, eol_n, bom_n;

	assign bytes.ready = !out_valid_q || verdict.ready;
	assign accept      = bytes.valid && bytes.ready;
	assign b           = bytes.data_byte;
	assign cfg.ready   = 1'b1;

	assign verdict.valid         = out_valid_q;
	assign verdict.text_encoding = enc_q;
	assign verdict.code_page     = page_q;
	assign verdict.line_ending   = eol_q;
	assign verdict.bom_length    = bom_q;

	assign p_ge1 = (pos_q >= 13'd1);
	assign p_ge3 = (pos_q >= 13'd3);

	always_comb begin
		head_n[0] = (pos_q == 13'd0) ? b : head_q[0];
		head_n[1] = (pos_q == 13'd1) ? b : head_q[1];
		head_n[2] = (pos_q == 13'd2) ? b : head_q[2];
	end

	assign mark_utf8 = (head_n[0] == 8'hEF) && (head_n[1] == 8'hBB) && (head_n[2] == 8'hBF);

	// lenient UTF-8 and ASCII checks over the leading window
	always_comb begin
		ascii_n   = ascii_q;
		invalid_n = invalid_q;
		cont_n    = cont_q;
		if (pos_q < {1'b0, enc_window_q}) begin
			if (b[7]) ascii_n = 1'b0;
			if (!invalid_q) begin
				if (cont_q != 3'd0) begin
					if (b[7:6] != 2'b10) invalid_n = 1'b1;
					cont_n = cont_q - 3'd1;
				end else if (b[7]) begin
					case (b) inside
						[8'h80:8'hBF]: invalid_n = 1'b1;
						[8'hC0:8'hDF]: cont_n = 3'd1;
						[8'hE0:8'hEF]: cont_n = 3'd2;
						[8'hF0:8'hF7]: cont_n = 3'd3;
						[8'hF8:8'hFB]: cont_n = 3'd4;
						[8'hFC:8'hFD]: cont_n = 3'd5;
						default:       invalid_n = 1'b1;
					endcase
				end
			end
		end
	end

	// line ending patterns; the UTF-8 mark widens the byte window by three
	assign byte_limit = {1'b0, eol_window_q} + ((p_ge3 && mark_utf8) ? 9'd3 : 9'd0);
	assign wide_limit = {1'b0, eol_window_q} + 9'd2;

	always_comb begin
		flags_byte_n = flags_byte_q;
		flags_le_n   = flags_le_q;
		flags_be_n   = flags_be_q;
		if (pos_q < {4'd0, byte_limit}) begin
			if (p_ge1 && recent_q[0] == CHAR_CR && b == CHAR_LF) flags_byte_n[0] = 1'b1;
			if (b == CHAR_LF) flags_byte_n[1] = 1'b1;
			if (b == CHAR_CR) flags_byte_n[2] = 1'b1;
		end
		if (pos_q < {4'd0, wide_limit}) begin
			if (p_ge3 && recent_q[2] == CHAR_CR && recent_q[1] == CHAR_NUL
				&& recent_q[0] == CHAR_LF && b == CHAR_NUL)
				flags_le_n[0] = 1'b1;
			if (p_ge1 && recent_q[0] == CHAR_LF && b == CHAR_NUL) flags_le_n[1] = 1'b1;
			if (p_ge1 && recent_q[0] == CHAR_CR && b == CHAR_NUL) flags_le_n[2] = 1'b1;
			if (p_ge3 && recent_q[2] == CHAR_NUL && recent_q[1] == CHAR_CR
				&& recent_q[0] == CHAR_NUL && b == CHAR_LF)
				flags_be_n[0] = 1'b1;
			if (p_ge1 && recent_q[0] == CHAR_NUL && b == CHAR_LF) flags_be_n[1] = 1'b1;
			if (p_ge1 && recent_q[0] == CHAR_NUL && b == CHAR_CR) flags_be_n[2] = 1'b1;
		end
	end

	always_comb begin
		enc_n  = ENC_ANSI;
		page_n = CP_ENGLISH;
		eol_n  = EOL_CRLF;
		bom_n  = BOM_NONE;
		if (pos_q >= 13'd2) begin
			if (head_n[0] == 8'hFF && head_n[1] == 8'hFE) begin
				enc_n  = ENC_UTF16LE;
				page_n = CP_UNICODE;
				bom_n  = BOM_UTF16;
				eol_n  = pick_ending(flags_le_n);
			end else if (head_n[0] == 8'hFE && head_n[1] == 8'hFF) begin
				enc_n  = ENC_UTF16BE;
				page_n = CP_UNICODE;
				bom_n  = BOM_UTF16;
				eol_n  = pick_ending(flags_be_n);
			end else if (mark_utf8) begin
				enc_n  = ENC_UTF8;
				page_n = CP_UNICODE;
				bom_n  = BOM_UTF8;
				eol_n  = pick_ending(flags_byte_n);
			end else begin
				if (ascii_n) begin
					enc_n  = ENC_ANSI;
					page_n = CP_ENGLISH;
				end else if (!invalid_n) begin
					enc_n  = ENC_UTF8;
					page_n = CP_UNICODE;
				end else begin
					enc_n  = ENC_ANSI;
					page_n = CP_OEM;
				end
				eol_n = pick_ending(flags_byte_n);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_window_q <= ENC_WINDOW_RESET;
			eol_window_q <= EOL_WINDOW_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_ENCODING_WINDOW: enc_window_q <= cfg.data;
				REG_EOL_WINDOW:      eol_window_q <= cfg.data[7:0];
				default:             ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '{default: 8'h00};
			recent_q     <= '{default: 8'h00};
			pos_q        <= '0;
			ascii_q      <= 1'b1;
			invalid_q    <= 1'b0;
			cont_q       <= '0;
			flags_byte_q <= '0;
			flags_le_q   <= '0;
			flags_be_q   <= '0;
		end else if (accept) begin
			if (bytes.last_byte) begin
				head_q       <= '{default: 8'h00};
				recent_q     <= '{default: 8'h00};
				pos_q        <= '0;
				ascii_q      <= 1'b1;
				invalid_q    <= 1'b0;
				cont_q       <= '0;
				flags_byte_q <= '0;
				flags_le_q   <= '0;
				flags_be_q   <= '0;
			end else begin
				head_q       <= head_n;
				recent_q[2]  <= recent_q[1];
				recent_q[1]  <= recent_q[0];
				recent_q[0]  <= b;
				if (pos_q != POS_MAX) pos_q <= pos_q + 13'd1;
				ascii_q      <= ascii_n;
				invalid_q    <= invalid_n;
				cont_q       <= cont_n;
				flags_byte_q <= flags_byte_n;
				flags_le_q   <= flags_le_n;
				flags_be_q   <= flags_be_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && bytes.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && bytes.last_byte) begin
			enc_q  <= enc_n;
			page_q <= page_n;
			eol_q  <= eol_n;
			bom_q  <= bom_n;
		end
	end

	`TFS_ASSERT(a_stall_blocks_input, clk, arst_n, (out_valid_q && !verdict.ready) |-> !bytes.ready)
	`TFS_ASSERT(a_last_clears_pos, clk, arst_n, (accept && bytes.last_byte) |=> (pos_q == 13'd0))
	`TFS_ASSERT_NEVER(a_ascii_not_invalid, clk, arst_n, ascii_q && invalid_q)
	`TFS_ASSERT(a_mark_is_unicode, clk, arst_n, (out_valid_q && bom_q != BOM_NONE) |-> (page_q == CP_UNICODE))
	`TFS_ASSERT(a_utf16_bom_len, clk, arst_n, (out_valid_q && (enc_q == ENC_UTF16LE || enc_q == ENC_UTF16BE)) |-> (bom_q == BOM_UTF16))

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tfs_pkg::*;

	typedef struct packed {
		code_t enc;
		code_t page;
		code_t eol;
		code_t bom;
	} verdict_t;

	typedef struct {
		byte_val_t data;
		logic      last;
		bit        hold;
	} file_byte_t;

	typedef enum {ORDER_BYTE, ORDER_LE, ORDER_BE} unit_order_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tfs_in_if  byte_if();
	tfs_out_if verdict_if();
	tfs_cfg_if cfg_if();

	text_format_sniffer_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (byte_if),
		.verdict (verdict_if),
		.cfg     (cfg_if)
	);

	// sniffer state as the bench sees it
	cfg_data_t  enc_window;
	logic [7:0] eol_window;
	byte_val_t  head [3];
	pos_t       byte_pos;
	bit         all_ascii;
	bit         utf8_broken;
	logic [2:0] cont_left;
	byte_val_t  recent [3];
	eol_flags_t seen_byte;
	eol_flags_t seen_le;
	eol_flags_t seen_be;

	file_byte_t  pending_bytes[$];
	verdict_t    expected_verdicts[$];
	byte_val_t   file_buf[$];
	unit_order_t unit_order;

	int files_sent;
	int verdicts_seen;
	int bytes_sent;
	int mismatches;
	int settings_used;
	int enc_count [4];
	int burst_left;
	int gap_left;
	logic [11:0] stall_cnt;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_file_state();
		foreach (head[i]) head[i] = '0;
		foreach (recent[i]) recent[i] = '0;
		byte_pos = '0;
		all_ascii = 1'b1;
		utf8_broken = 1'b0;
		cont_left = '0;
		seen_byte = '0;
		seen_le = '0;
		seen_be = '0;
	endfunction

	function automatic code_t pick_eol(eol_flags_t f);
		if (f[0]) return EOL_CRLF;
		if (f[1]) return EOL_LF;
		if (f[2]) return EOL_CR;
		return EOL_CRLF;
	endfunction

	// Advance the sniffer by one byte; returns 1 with the verdict on the last byte.
	function automatic bit sniff_byte(byte_val_t b, logic last, output verdict_t v);
		int unsigned p;
		int unsigned byte_lim;
		int unsigned wide_lim;
		bit          utf8_mark;
		p = byte_pos;
		v = '{ENC_ANSI, CP_ENGLISH, EOL_CRLF, BOM_NONE};
		if (p < 3) head[p] = b;
		if (p < enc_window) begin
			if (b >= 8'h80) all_ascii = 1'b0;
			if (!utf8_broken) begin
				if (cont_left != 0) begin
					if (b[7:6] != 2'b10) utf8_broken = 1'b1;
					cont_left = cont_left - 3'd1;
				end else if (b >= 8'h80) begin
					if (b < 8'hC0 || b >= 8'hFE) utf8_broken = 1'b1;
					else if (b < 8'hE0) cont_left = 3'd1;
					else if (b < 8'hF0) cont_left = 3'd2;
					else if (b < 8'hF8) cont_left = 3'd3;
					else if (b < 8'hFC) cont_left = 3'd4;
					else cont_left = 3'd5;
				end
			end
		end
		utf8_mark = head[0] == 8'hEF && head[1] == 8'hBB && head[2] == 8'hBF;
		// mark bytes can never start a pattern, only the window shifts past them
		byte_lim = eol_window + ((p >= 3 && utf8_mark) ? 3 : 0);
		wide_lim = eol_window + 2;
		if (p < byte_lim) begin
			if (p >= 1 && recent[0] == CHAR_CR && b == CHAR_LF) seen_byte[0] = 1'b1;
			if (b == CHAR_LF) seen_byte[1] = 1'b1;
			if (b == CHAR_CR) seen_byte[2] = 1'b1;
		end
		if (p < wide_lim) begin
			if (p >= 3 && recent[2] == CHAR_CR && recent[1] == CHAR_NUL &&
					recent[0] == CHAR_LF && b == CHAR_NUL)
				seen_le[0] = 1'b1;
			if (p >= 1 && recent[0] == CHAR_LF && b == CHAR_NUL) seen_le[1] = 1'b1;
			if (p >= 1 && recent[0] == CHAR_CR && b == CHAR_NUL) seen_le[2] = 1'b1;
			if (p >= 3 && recent[2] == CHAR_NUL && recent[1] == CHAR_CR &&
					recent[0] == CHAR_NUL && b == CHAR_LF)
				seen_be[0] = 1'b1;
			if (p >= 1 && recent[0] == CHAR_NUL && b == CHAR_LF) seen_be[1] = 1'b1;
			if (p >= 1 && recent[0] == CHAR_NUL && b == CHAR_CR) seen_be[2] = 1'b1;
		end
		recent[2] = recent[1];
		recent[1] = recent[0];
		recent[0] = b;
		if (byte_pos != POS_MAX) byte_pos = byte_pos + 1'b1;
		if (!last) return 1'b0;
		if (p >= 2) begin
			if (head[0] == 8'hFF && head[1] == 8'hFE)
				v = '{ENC_UTF16LE, CP_UNICODE, pick_eol(seen_le), BOM_UTF16};
			else if (head[0] == 8'hFE && head[1] == 8'hFF)
				v = '{ENC_UTF16BE, CP_UNICODE, pick_eol(seen_be), BOM_UTF16};
			else if (utf8_mark)
				v = '{ENC_UTF8, CP_UNICODE, pick_eol(seen_byte), BOM_UTF8};
			else if (all_ascii)
				v = '{ENC_ANSI, CP_ENGLISH, pick_eol(seen_byte), BOM_NONE};
			else if (!utf8_broken)
				v = '{ENC_UTF8, CP_UNICODE, pick_eol(seen_byte), BOM_NONE};
			else
				v = '{ENC_ANSI, CP_OEM, pick_eol(seen_byte), BOM_NONE};
		end
		clear_file_state();
		return 1'b1;
	endfunction

	// byte channel: bursts with gaps, optional hold until all verdicts are in
	always @(posedge clk) begin
		verdict_t   v;
		file_byte_t nb;
		bit         pushed;
		pushed = 1'b0;
		if (!arst_n) begin
			byte_if.valid <= 1'b0;
			byte_if.data_byte <= '0;
			byte_if.last_byte <= 1'b0;
			clear_file_state();
		end else begin
			if (byte_if.valid && byte_if.ready) begin
				bytes_sent <= bytes_sent + 1;
				if (sniff_byte(byte_if.data_byte, byte_if.last_byte, v)) begin
					expected_verdicts = {expected_verdicts, v};
					enc_count[v.enc]++;
					pushed = 1'b1;
				end
			end
			files_sent <= files_sent + pushed;
			if (!byte_if.valid || byte_if.ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					byte_if.valid <= 1'b0;
				end else if (pending_bytes.size() != 0 && !(pending_bytes[0].hold &&
						files_sent + pushed != verdicts_seen)) begin
					nb = pending_bytes.pop_front();
					byte_if.valid <= 1'b1;
					byte_if.data_byte <= nb.data;
					byte_if.last_byte <= nb.last;
					if (burst_left > 1) begin
						burst_left <= burst_left - 1;
					end else begin
						burst_left <= ($urandom_range(0, 7) == 0) ?
							$urandom_range(60, 200) : $urandom_range(1, 16);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					byte_if.valid <= 1'b0;
				end
			end
		end
	end

	task automatic flag_mismatch(string what, verdict_t want, verdict_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d (enc/page/eol/bom)",
				$time, what, want.enc, want.page, want.eol, want.bom,
				got.enc, got.page, got.eol, got.bom);
	endtask

	// verdict channel: checker plus a rotating stall pattern
	always @(posedge clk) begin
		verdict_t want;
		verdict_t got;
		if (!arst_n) begin
			verdict_if.ready <= 1'b0;
			stall_cnt <= '0;
		end else begin
			if (verdict_if.valid && verdict_if.ready) begin
				got = '{verdict_if.text_encoding, verdict_if.code_page,
					verdict_if.line_ending, verdict_if.bom_length};
				if (expected_verdicts.size() == 0) begin
					want = '0;
					flag_mismatch("unexpected verdict", want, got);
				end else begin
					want = expected_verdicts.pop_front();
					verdicts_seen <= verdicts_seen + 1;
					if (got.enc !== want.enc || got.page !== want.page ||
							got.eol !== want.eol || got.bom !== want.bom)
						flag_mismatch("verdict mismatch", want, got);
				end
			end
			stall_cnt <= stall_cnt + 1'b1;
			case (stall_cnt[11:9])
				3'd0, 3'd1: verdict_if.ready <= 1'b1;
				3'd2:       verdict_if.ready <= stall_cnt[0];
				3'd3:       verdict_if.ready <= stall_cnt[2:0] != 3'd0;
				3'd6:       verdict_if.ready <= stall_cnt[3:0] < 4'd4;
				default:    verdict_if.ready <= $urandom_range(0, 3) != 0;
			endcase
		end
	end

	task automatic put_byte(byte_val_t v);
		file_buf = {file_buf, v};
	endtask

	task automatic put_unit(byte_val_t lo, byte_val_t hi);
		case (unit_order)
			ORDER_BYTE: put_byte(lo);
			ORDER_LE: begin
				put_byte(lo);
				put_byte(hi);
			end
			default: begin
				put_byte(hi);
				put_byte(lo);
			end
		endcase
	endtask

	task automatic put_eol(code_t kind);
		case (kind)
			EOL_CRLF: begin
				put_unit(CHAR_CR, CHAR_NUL);
				put_unit(CHAR_LF, CHAR_NUL);
			end
			EOL_LF:  put_unit(CHAR_LF, CHAR_NUL);
			default: put_unit(CHAR_CR, CHAR_NUL);
		endcase
	endtask

	task automatic put_utf8_seq();
		int        len;
		byte_val_t lead;
		len = $urandom_range(2, 6);
		case (len)
			2:       lead = 8'($urandom_range(8'hC0, 8'hDF));
			3:       lead = 8'($urandom_range(8'hE0, 8'hEF));
			4:       lead = 8'($urandom_range(8'hF0, 8'hF7));
			5:       lead = 8'($urandom_range(8'hF8, 8'hFB));
			default: lead = 8'($urandom_range(8'hFC, 8'hFD));
		endcase
		put_byte(lead);
		repeat (len - 1) put_byte(8'($urandom_range(8'h80, 8'hBF)));
	endtask

	task automatic put_text(int n, code_t style, bit mixed, bit multibyte);
		int r;
		repeat (n) begin
			r = $urandom_range(0, 11);
			if (r == 0)
				put_eol(mixed ? code_t'($urandom_range(0, 2)) : style);
			else if (r <= 3 && multibyte && unit_order == ORDER_BYTE)
				put_utf8_seq();
			else if (r == 1 && unit_order != ORDER_BYTE)
				put_unit(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			else
				put_unit(8'($urandom_range(32, 126)), CHAR_NUL);
		end
	endtask

	task automatic queue_file(input bit hold, output int len);
		file_byte_t fb;
		if (file_buf.size() == 0) put_byte(8'($urandom_range(0, 255)));
		len = file_buf.size();
		foreach (file_buf[i]) begin
			fb = '{file_buf[i], i == len - 1, hold && i == 0};
			pending_bytes = {pending_bytes, fb};
		end
		file_buf.delete();
	endtask

	task automatic random_file(input bit hold, output int len);
		int    n;
		code_t style;
		bit    mixed;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 300) : $urandom_range(0, 40);
		style = code_t'($urandom_range(0, 2));
		mixed = $urandom_range(0, 2) == 0;
		unit_order = ORDER_BYTE;
		case ($urandom_range(0, 11))
			0, 1: put_text(n, style, mixed, 1'b0);
			2: put_text(n, style, mixed, 1'b1);
			3: begin
				file_buf = {8'hEF, 8'hBB, 8'hBF};
				put_text(n, style, mixed, 1'b1);
			end
			4: begin
				file_buf = {8'hFF, 8'hFE};
				unit_order = ORDER_LE;
				put_text(n, style, mixed, 1'b0);
			end
			5: begin
				file_buf = {8'hFE, 8'hFF};
				unit_order = ORDER_BE;
				put_text(n, style, mixed, 1'b0);
			end
			6: repeat (n + 1) begin
				case ($urandom_range(0, 5))
					0:       put_byte(CHAR_CR);
					1:       put_byte(CHAR_LF);
					2:       put_byte(CHAR_NUL);
					default: put_byte(8'($urandom_range(0, 255)));
				endcase
			end
			7: begin
				// invalid UTF-8 somewhere in the middle
				put_text(n / 2, style, mixed, 1'b1);
				case ($urandom_range(0, 2))
					0: put_byte(8'($urandom_range(8'h80, 8'hBF)));
					1: put_byte(8'($urandom_range(8'hFE, 8'hFF)));
					default: begin
						put_byte(8'hC3);
						put_byte(8'h41);
					end
				endcase
				put_text(n / 2, style, mixed, 1'b1);
			end
			8: repeat ($urandom_range(1, 2)) put_byte(8'($urandom_range(0, 255)));
			9: case ($urandom_range(0, 3))
				0:       file_buf = {8'hFF, 8'hFE};
				1:       file_buf = {8'hFE, 8'hFF};
				2:       file_buf = {8'hEF, 8'hBB};
				default: file_buf = {8'hEF, 8'hBB, 8'hBF};
			endcase
			10: begin
				// almost a mark, or at times a full UTF-16 mark
				case ($urandom_range(0, 2))
					0:       put_byte(8'hEF);
					1:       put_byte(8'hFF);
					default: put_byte(8'hFE);
				endcase
				case ($urandom_range(0, 3))
					0:       put_byte(8'hBB);
					1:       put_byte(8'hFE);
					2:       put_byte(8'hFF);
					default: put_byte(8'($urandom_range(0, 255)));
				endcase
				put_text(n, style, mixed, 1'b1);
			end
			default: begin
				// sequence cut off by the end of the file
				put_text(n, style, mixed, 1'b1);
				put_byte(8'($urandom_range(8'hC0, 8'hFD)));
			end
		endcase
		queue_file(hold, len);
	endtask

	task automatic write_reg(cfg_idx_t idx, cfg_data_t value);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= value;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		if (idx == REG_ENCODING_WINDOW) enc_window = value;
		else eol_window = value[7:0];
	endtask

	task automatic wait_idle(int tail);
		do @(negedge clk);
		while (pending_bytes.size() != 0 || byte_if.valid || expected_verdicts.size() != 0);
		repeat (tail) @(negedge clk);
	endtask

	initial begin
		int         len;
		int         budget;
		cfg_data_t  ew;
		logic [7:0] lw;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_ENCODING_WINDOW;
		cfg_if.data = '0;
		enc_window = ENC_WINDOW_RESET;
		eol_window = EOL_WINDOW_RESET;
		settings_used = 1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed files, register defaults
		file_buf = {8'h00};
		queue_file(1'b0, len);
		file_buf = {8'hFF, 8'hFE};
		queue_file(1'b0, len);
		file_buf = {8'hFF, 8'hFE, 8'h0D, 8'h00, 8'h0A, 8'h00};
		queue_file(1'b0, len);
		file_buf = {8'hFE, 8'hFF, 8'h00, 8'h0A};
		queue_file(1'b0, len);
		file_buf = {8'hEF, 8'hBB, 8'hBF, 8'h0D};
		queue_file(1'b0, len);
		file_buf = {8'hC3, 8'hA9, 8'h0A};
		queue_file(1'b0, len);
		file_buf = {8'h80, 8'h41, 8'h0D, 8'h0A};
		queue_file(1'b0, len);

		for (int ph = 0; ph < 9; ph++) begin
			if (ph > 0) begin
				case (ph)
					1: begin
						ew = 12'd4095;
						lw = 8'd255;
					end
					2: begin
						ew = 12'd1;
						lw = 8'd1;
					end
					3: begin
						ew = 12'd0;
						lw = 8'd0;
					end
					default: begin
						ew = ($urandom_range(0, 1) == 0) ?
							12'($urandom_range(1, 40)) : 12'($urandom_range(1, 4095));
						lw = ($urandom_range(0, 1) == 0) ?
							8'($urandom_range(1, 12)) : 8'($urandom_range(1, 255));
					end
				endcase
				wait_idle(4);
				write_reg(REG_ENCODING_WINDOW, ew);
				// upper data bits of the eol register are don't-care
				write_reg(REG_EOL_WINDOW, {4'($urandom_range(0, 15)), lw});
				settings_used++;
				@(negedge clk);
			end
			if (ph == 2) begin
				// window edge at one byte: lead inside, broken continuation just outside
				file_buf = {8'hC3, 8'h41, 8'h41};
				queue_file(1'b0, len);
			end
			budget = 160;
			while (budget > 0) begin
				random_file((ph == 0 && budget == 160) || $urandom_range(0, 24) == 0, len);
				budget -= len;
			end
		end

		wait_idle(32);
		$display("covered %0d files, %0d bytes, %0d register settings",
			files_sent, bytes_sent, settings_used);
		$display("verdicts by encoding: ansi %0d, utf16le %0d, utf16be %0d, utf8 %0d",
			enc_count[ENC_ANSI], enc_count[ENC_UTF16LE], enc_count[ENC_UTF16BE],
			enc_count[ENC_UTF8]);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/tfs_pkg.sv
rtl/core/tfs_intf.sv
rtl/core/text_format_sniffer_unit.sv
bench/tb_top.sv
